[hw/rtl/pmc_pkg.sv]
// Shared types and constants of the PI position controller.
// No dependencies; every other file of the block refers to it by scoped names.
package pmc_pkg;

   localparam int STOP_WINDOW_BITS = 10;
   localparam int DUTY_BITS        = 8;
   localparam int LIMIT_BITS       = 14;
   localparam int GAIN_BITS        = 8;
   localparam int INTEG_BITS       = 15;
   localparam int DIR_BITS         = 2;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 14;

   localparam int KP_DIVISOR = 10;
   localparam int KI_DIVISOR = 100;
   localparam int DUTY_MAX   = 255;

   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_WINDOW    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_DUTY       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INTEGRAL_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KP_NUMERATOR   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KI_NUMERATOR   = 3'd4;

   localparam logic [STOP_WINDOW_BITS-1:0] RESET_STOP_WINDOW    = 10'd2;
   localparam logic [DUTY_BITS-1:0]        RESET_MIN_DUTY       = 8'd100;
   localparam logic [LIMIT_BITS-1:0]       RESET_INTEGRAL_LIMIT = 14'd5000;
   localparam logic [GAIN_BITS-1:0]        RESET_KP_NUMERATOR   = 8'd4;
   localparam logic [GAIN_BITS-1:0]        RESET_KI_NUMERATOR   = 8'd5;

   localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_CW   = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_CCW  = 2'd2;

   typedef struct packed {
      logic [STOP_WINDOW_BITS-1:0] stop_window;
      logic [DUTY_BITS-1:0]        min_duty;
      logic [LIMIT_BITS-1:0]       integral_limit;
      logic [GAIN_BITS-1:0]        kp_numerator;
      logic [GAIN_BITS-1:0]        ki_numerator;
   } cfg_type;

   // per-transaction control carried down the pipe
   typedef struct packed {
      logic stop;
      logic p_neg;
      logic i_neg;
   } sign_type;

endpackage

[hw/rtl/pmc_if.sv]
// Valid/ready channel interfaces of the PI position controller.
// Uses pmc_pkg for the result field widths.
interface pmc_req_if #(parameter int SAMPLE_BITS = 10);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] reference_sample;
   logic [SAMPLE_BITS-1:0] measured_sample;

   modport source (output valid, output reference_sample, output measured_sample,
                   input ready);
   modport sink   (input valid, input reference_sample, input measured_sample,
                   output ready);
endinterface

interface pmc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pmc_pkg::DUTY_BITS-1:0]  duty;
   logic [pmc_pkg::DIR_BITS-1:0]   direction;

   modport source (output valid, output duty, output direction, input ready);
   modport sink   (input valid, input duty, input direction, output ready);
endinterface

[hw/rtl/pi_motor_position_controller.sv]
// PI position controller with dead band: top level, CSR file and pipeline control.
// Depends on pmc_pkg, pmc_if and the pmc_integ_stage, pmc_gain_stage and
// pmc_duty_stage modules.
//
// Usage: each req_chan transaction carries a reference and a measured sample; each
// one yields exactly one rsp_chan transaction with duty and direction
// (0 stop, 1 clockwise, 2 counter-clockwise), in order.
// Throughput: one transaction per cycle while rsp_chan takes results. The integrator
// add and clamp is a feedback loop through its own register, which sets that figure.
// Pipeline: five stages (input register, integrator, gain products, quotient
// estimate, result register); rsp_chan.valid comes from the result register.
// Each stage holds while its successor is full and stalled, so req_chan.ready
// stays high while empty stages remain, even with a result waiting on rsp_chan.
// Reset (synchronous): pipeline empties, integrator clears, CSRs take defaults
// (dead band 2, min duty 100, limit 5000, kp 4, ki 5).
// CSRs: csr_we writes csr_wdata (low bits) into register csr_index;
// indexes past the last register are ignored. Write only while idle.
module pi_motor_position_controller #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pmc_req_if.sink                              req_chan,
   pmc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [pmc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pmc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int STAGES = 5;
   localparam int PW  = SAMPLE_BITS + pmc_pkg::GAIN_BITS;
   localparam int IPW = pmc_pkg::LIMIT_BITS + pmc_pkg::GAIN_BITS;

   pmc_pkg::cfg_type cfg_ff;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;
   logic [STAGES-1:0] load;

   logic [SAMPLE_BITS-1:0] ref_ff;
   logic [SAMPLE_BITS-1:0] meas_ff;

   logic [SAMPLE_BITS-1:0]         err_mag;
   logic [pmc_pkg::LIMIT_BITS-1:0] integ_mag;
   pmc_pkg::sign_type              flags_s1;
   logic [PW-4:0]                  quot_p;
   logic [PW-1:0]                  prod_p;
   logic [IPW-7:0]                 quot_i;
   logic [IPW-1:0]                 prod_i;
   pmc_pkg::sign_type              flags_s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_window    <= pmc_pkg::RESET_STOP_WINDOW;
         cfg_ff.min_duty       <= pmc_pkg::RESET_MIN_DUTY;
         cfg_ff.integral_limit <= pmc_pkg::RESET_INTEGRAL_LIMIT;
         cfg_ff.kp_numerator   <= pmc_pkg::RESET_KP_NUMERATOR;
         cfg_ff.ki_numerator   <= pmc_pkg::RESET_KI_NUMERATOR;
      end else if (csr_we) begin
         case (csr_index)
            pmc_pkg::REG_STOP_WINDOW: begin
               cfg_ff.stop_window <= csr_wdata[pmc_pkg::STOP_WINDOW_BITS-1:0];
            end
            pmc_pkg::REG_MIN_DUTY: begin
               cfg_ff.min_duty <= csr_wdata[pmc_pkg::DUTY_BITS-1:0];
            end
            pmc_pkg::REG_INTEGRAL_LIMIT: begin
               cfg_ff.integral_limit <= csr_wdata[pmc_pkg::LIMIT_BITS-1:0];
            end
            pmc_pkg::REG_KP_NUMERATOR: begin
               cfg_ff.kp_numerator <= csr_wdata[pmc_pkg::GAIN_BITS-1:0];
            end
            pmc_pkg::REG_KI_NUMERATOR: begin
               cfg_ff.ki_numerator <= csr_wdata[pmc_pkg::GAIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // a stage takes a new transaction when it is empty or its successor moves
   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || rsp_chan.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      load[0]     = rdy[0] && req_chan.valid;
      valid_in[0] = rdy[0] ? req_chan.valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         load[k]     = rdy[k] && valid_ff[k-1];
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ref_ff  <= req_chan.reference_sample;
         meas_ff <= req_chan.measured_sample;
      end
   end

   pmc_integ_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_integ (
      .clock            (clock),
      .reset            (reset),
      .load             (load[1]),
      .reference_sample (ref_ff),
      .measured_sample  (meas_ff),
      .cfg              (cfg_ff),
      .err_mag          (err_mag),
      .integ_mag        (integ_mag),
      .flags            (flags_s1)
   );

   pmc_gain_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_gain (
      .clock     (clock),
      .load_prod (load[2]),
      .load_quot (load[3]),
      .err_mag   (err_mag),
      .integ_mag (integ_mag),
      .flags     (flags_s1),
      .cfg       (cfg_ff),
      .quot_p    (quot_p),
      .prod_p    (prod_p),
      .quot_i    (quot_i),
      .prod_i    (prod_i),
      .flags_out (flags_s3)
   );

   pmc_duty_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_duty (
      .clock     (clock),
      .load      (load[4]),
      .quot_p    (quot_p),
      .prod_p    (prod_p),
      .quot_i    (quot_i),
      .prod_i    (prod_i),
      .flags     (flags_s3),
      .min_duty  (cfg_ff.min_duty),
      .duty      (rsp_chan.duty),
      .direction (rsp_chan.direction)
   );

   assign req_chan.ready = rdy[0];
   assign rsp_chan.valid = valid_ff[STAGES-1];

`ifndef SYNTH
   a_stop_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.direction == pmc_pkg::DIR_STOP) |-> rsp_chan.duty == '0)
      else $error("stop result with nonzero duty");

   a_run_min_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.direction != pmc_pkg::DIR_STOP)
         |-> rsp_chan.duty >= cfg_ff.min_duty)
      else $error("running result below min duty");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_chan.valid && req_chan.ready))
      else $error("pipeline not empty after reset");
`endif

endmodule

[hw/rtl/pmc_integ_stage.sv]
// Error, dead band decision and clamped integrator update.
// Depends on pmc_pkg; the integrator loop closes here through integ_ff.
module pmc_integ_stage #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [SAMPLE_BITS-1:0]            reference_sample,
   input  logic [SAMPLE_BITS-1:0]            measured_sample,
   input  pmc_pkg::cfg_type                  cfg,
   output logic [SAMPLE_BITS-1:0]            err_mag,
   output logic [pmc_pkg::LIMIT_BITS-1:0]    integ_mag,
   output pmc_pkg::sign_type                 flags
);

   localparam int EW = SAMPLE_BITS + 1;
   localparam int CW = (SAMPLE_BITS > pmc_pkg::STOP_WINDOW_BITS) ?
                       SAMPLE_BITS : pmc_pkg::STOP_WINDOW_BITS;
   localparam int SW = ((EW > pmc_pkg::INTEG_BITS) ? EW : pmc_pkg::INTEG_BITS) + 1;
   localparam int IW = pmc_pkg::INTEG_BITS;

   logic signed [EW-1:0] err;
   logic        [EW-1:0] err_abs;
   logic                 stop;
   logic signed [SW-1:0] acc;
   logic signed [SW-1:0] lim_s;
   logic signed [SW-1:0] clamped;
   logic signed [IW-1:0] integ_in;
   logic        [IW-1:0] integ_abs;
   logic signed [IW-1:0] integ_ff;

   logic [SAMPLE_BITS-1:0]         err_mag_ff;
   logic [pmc_pkg::LIMIT_BITS-1:0] integ_mag_ff;
   pmc_pkg::sign_type              flags_ff;
   pmc_pkg::sign_type              flags_in;

   always_comb begin
      err     = $signed({1'b0, reference_sample}) - $signed({1'b0, measured_sample});
      err_abs = err[EW-1] ? EW'(-err) : EW'(err);
      stop    = CW'(err_abs[SAMPLE_BITS-1:0]) <= CW'(cfg.stop_window);

      acc   = SW'(err) + SW'(integ_ff);
      lim_s = SW'(cfg.integral_limit);
      if (acc > lim_s) begin
         clamped = lim_s;
      end else if (acc < -lim_s) begin
         clamped = -lim_s;
      end else begin
         clamped = acc;
      end

      integ_in  = stop ? '0 : IW'(clamped);
      integ_abs = integ_in[IW-1] ? IW'(-integ_in) : IW'(integ_in);

      flags_in.stop  = stop;
      flags_in.p_neg = err[EW-1];
      flags_in.i_neg = integ_in[IW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (load) begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_mag_ff   <= err_abs[SAMPLE_BITS-1:0];
         integ_mag_ff <= integ_abs[pmc_pkg::LIMIT_BITS-1:0];
         flags_ff     <= flags_in;
      end
   end

   assign err_mag   = err_mag_ff;
   assign integ_mag = integ_mag_ff;
   assign flags     = flags_ff;

endmodule

[hw/rtl/pmc_gain_stage.sv]
// Gain products and reciprocal quotient estimates for the divide by 10 and 100.
// Depends on pmc_pkg; two register levels, one multiplier each per term.
module pmc_gain_stage #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                      clock,
   input  logic                                      load_prod,
   input  logic                                      load_quot,
   input  logic [SAMPLE_BITS-1:0]                    err_mag,
   input  logic [pmc_pkg::LIMIT_BITS-1:0]            integ_mag,
   input  pmc_pkg::sign_type                         flags,
   input  pmc_pkg::cfg_type                          cfg,
   output logic [SAMPLE_BITS+pmc_pkg::GAIN_BITS-4:0] quot_p,
   output logic [SAMPLE_BITS+pmc_pkg::GAIN_BITS-1:0] prod_p,
   output logic [pmc_pkg::LIMIT_BITS+pmc_pkg::GAIN_BITS-7:0] quot_i,
   output logic [pmc_pkg::LIMIT_BITS+pmc_pkg::GAIN_BITS-1:0] prod_i,
   output pmc_pkg::sign_type                         flags_out
);

   // products stay below 2**PW, so floor(2**PW/D) gives an estimate low by at most one
   localparam int PW  = SAMPLE_BITS + pmc_pkg::GAIN_BITS;
   localparam int RW  = PW - 3;
   localparam int IPW = pmc_pkg::LIMIT_BITS + pmc_pkg::GAIN_BITS;
   localparam int RIW = IPW - 6;
   localparam logic [RW-1:0]  RECIP_P = RW'((64'd1 << PW) / pmc_pkg::KP_DIVISOR);
   localparam logic [RIW-1:0] RECIP_I = RIW'((64'd1 << IPW) / pmc_pkg::KI_DIVISOR);

   logic [PW-1:0]      prod_p_ff;
   logic [IPW-1:0]     prod_i_ff;
   pmc_pkg::sign_type  flags_a_ff;

   logic [PW+RW-1:0]   full_p;
   logic [IPW+RIW-1:0] full_i;

   logic [RW-1:0]      quot_p_ff;
   logic [PW-1:0]      mag_p_ff;
   logic [RIW-1:0]     quot_i_ff;
   logic [IPW-1:0]     mag_i_ff;
   pmc_pkg::sign_type  flags_b_ff;

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_p_ff  <= PW'(err_mag) * PW'(cfg.kp_numerator);
         prod_i_ff  <= IPW'(integ_mag) * IPW'(cfg.ki_numerator);
         flags_a_ff <= flags;
      end
   end

   always_comb begin
      full_p = (PW+RW)'(prod_p_ff) * (PW+RW)'(RECIP_P);
      full_i = (IPW+RIW)'(prod_i_ff) * (IPW+RIW)'(RECIP_I);
   end

   always_ff @(posedge clock) begin
      if (load_quot) begin
         quot_p_ff  <= full_p[PW+RW-1:PW];
         mag_p_ff   <= prod_p_ff;
         quot_i_ff  <= full_i[IPW+RIW-1:IPW];
         mag_i_ff   <= prod_i_ff;
         flags_b_ff <= flags_a_ff;
      end
   end

   assign quot_p    = quot_p_ff;
   assign prod_p    = mag_p_ff;
   assign quot_i    = quot_i_ff;
   assign prod_i    = mag_i_ff;
   assign flags_out = flags_b_ff;

endmodule

[hw/rtl/pmc_duty_stage.sv]
// Quotient correction, term sum, duty saturation and direction; result register.
// Depends on pmc_pkg.
module pmc_duty_stage #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                      clock,
   input  logic                                      load,
   input  logic [SAMPLE_BITS+pmc_pkg::GAIN_BITS-4:0] quot_p,
   input  logic [SAMPLE_BITS+pmc_pkg::GAIN_BITS-1:0] prod_p,
   input  logic [pmc_pkg::LIMIT_BITS+pmc_pkg::GAIN_BITS-7:0] quot_i,
   input  logic [pmc_pkg::LIMIT_BITS+pmc_pkg::GAIN_BITS-1:0] prod_i,
   input  pmc_pkg::sign_type                         flags,
   input  logic [pmc_pkg::DUTY_BITS-1:0]             min_duty,
   output logic [pmc_pkg::DUTY_BITS-1:0]             duty,
   output logic [pmc_pkg::DIR_BITS-1:0]              direction
);

   localparam int PW  = SAMPLE_BITS + pmc_pkg::GAIN_BITS;
   localparam int RW  = PW - 3;
   localparam int IPW = pmc_pkg::LIMIT_BITS + pmc_pkg::GAIN_BITS;
   localparam int RIW = IPW - 6;
   localparam int TW  = ((RW > RIW) ? RW : RIW) + 1;
   localparam int UW  = TW + 1;

   logic [PW-1:0]         rem_p;
   logic [IPW-1:0]        rem_i;
   logic [RW-1:0]         qp;
   logic [RIW-1:0]        qi;
   logic signed [TW-1:0]  qp_s;
   logic signed [TW-1:0]  qi_s;
   logic signed [TW-1:0]  pterm;
   logic signed [TW-1:0]  iterm;
   logic signed [UW-1:0]  sum;
   logic        [UW-1:0]  amag;
   logic [pmc_pkg::DUTY_BITS-1:0] sat;
   logic [pmc_pkg::DUTY_BITS-1:0] duty_in;
   logic [pmc_pkg::DIR_BITS-1:0]  dir_in;

   logic [pmc_pkg::DUTY_BITS-1:0] duty_ff;
   logic [pmc_pkg::DIR_BITS-1:0]  direction_ff;

   always_comb begin
      // estimate is exact or one short
      rem_p = prod_p - PW'(quot_p) * PW'(pmc_pkg::KP_DIVISOR);
      rem_i = prod_i - IPW'(quot_i) * IPW'(pmc_pkg::KI_DIVISOR);
      qp    = (rem_p >= PW'(pmc_pkg::KP_DIVISOR)) ? quot_p + 1'b1 : quot_p;
      qi    = (rem_i >= IPW'(pmc_pkg::KI_DIVISOR)) ? quot_i + 1'b1 : quot_i;

      // truncation toward zero: divide the magnitude, then restore the sign
      qp_s  = TW'(qp);
      qi_s  = TW'(qi);
      pterm = flags.p_neg ? -qp_s : qp_s;
      iterm = flags.i_neg ? -qi_s : qi_s;
      sum   = UW'(pterm) + UW'(iterm);
      amag  = sum[UW-1] ? UW'(-sum) : UW'(sum);

      sat = (amag > UW'(pmc_pkg::DUTY_MAX)) ? pmc_pkg::DUTY_BITS'(pmc_pkg::DUTY_MAX) :
                                              amag[pmc_pkg::DUTY_BITS-1:0];

      if (flags.stop) begin
         duty_in = '0;
         dir_in  = pmc_pkg::DIR_STOP;
      end else begin
         duty_in = (sat < min_duty) ? min_duty : sat;
         dir_in  = (sum > UW'(0)) ? pmc_pkg::DIR_CW : pmc_pkg::DIR_CCW;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         duty_ff      <= duty_in;
         direction_ff <= dir_in;
      end
   end

   assign duty      = duty_ff;
   assign direction = direction_ff;

endmodule

[tb/tb_pi_motor_position_controller.sv]
// Self-checking testbench for the PI position controller with dead band.
// Needs pmc_pkg, the pmc_req_if/pmc_rsp_if interfaces and the controller RTL.
// A local model predicts duty and direction for each accepted sample pair.
module tb_pi_motor_position_controller;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS    = 10;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int PIPE_DEPTH     = 5;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 250;
   localparam int INDEX_BITS     = pmc_pkg::CSR_INDEX_BITS;
   localparam int DATA_BITS      = pmc_pkg::CSR_DATA_BITS;
   localparam int DUTY_MAX       = pmc_pkg::DUTY_MAX;
   localparam logic [DATA_BITS-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [pmc_pkg::DUTY_BITS-1:0] duty;
      logic [pmc_pkg::DIR_BITS-1:0]  direction;
   } drive_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [INDEX_BITS-1:0] csr_index;
   logic [DATA_BITS-1:0]  csr_wdata;

   pmc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   pmc_rsp_if rsp_chan ();

   pi_motor_position_controller #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // controller model state
   pmc_pkg::cfg_type reg_model;
   int               integ_model;

   drive_type expected_drives[$];
   int     error_count = 0;
   int     sender_idle_odds = 0;
   int     receiver_idle_odds = 0;
   int     quiet_cycles = 0;

   function automatic drive_type compute_drive(int ref_val, int meas_val);
      int err, mag, lim, pterm, iterm, total, amag, duty;
      drive_type d;
      err = ref_val - meas_val;
      mag = (err < 0) ? -err : err;
      if (mag <= int'(reg_model.stop_window)) begin
         integ_model = 0;
         d.duty = '0;
         d.direction = pmc_pkg::DIR_STOP;
         return d;
      end
      lim = int'(reg_model.integral_limit);
      integ_model = integ_model + err;
      if (integ_model > lim)
         integ_model = lim;
      else if (integ_model < -lim)
         integ_model = -lim;
      pterm = (err * int'(reg_model.kp_numerator)) / pmc_pkg::KP_DIVISOR;
      iterm = (integ_model * int'(reg_model.ki_numerator)) / pmc_pkg::KI_DIVISOR;
      total = pterm + iterm;
      amag = (total < 0) ? -total : total;
      duty = (amag > DUTY_MAX) ? DUTY_MAX : amag;
      if (duty < int'(reg_model.min_duty))
         duty = int'(reg_model.min_duty);
      d.duty = duty[pmc_pkg::DUTY_BITS-1:0];
      d.direction = (total > 0) ? pmc_pkg::DIR_CW : pmc_pkg::DIR_CCW;
      return d;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // one CSR write; the model takes the same masked value
   task automatic write_reg(logic [INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         pmc_pkg::REG_STOP_WINDOW:
            reg_model.stop_window = data[pmc_pkg::STOP_WINDOW_BITS-1:0];
         pmc_pkg::REG_MIN_DUTY:
            reg_model.min_duty = data[pmc_pkg::DUTY_BITS-1:0];
         pmc_pkg::REG_INTEGRAL_LIMIT:
            reg_model.integral_limit = data[pmc_pkg::LIMIT_BITS-1:0];
         pmc_pkg::REG_KP_NUMERATOR:
            reg_model.kp_numerator = data[pmc_pkg::GAIN_BITS-1:0];
         pmc_pkg::REG_KI_NUMERATOR:
            reg_model.ki_numerator = data[pmc_pkg::GAIN_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_for_idle();
      req_chan.valid <= 1'b0;
      while (expected_drives.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   task automatic send_sample(int ref_val, int meas_val);
      if (sender_idle_odds != 0 && $urandom_range(1, sender_idle_odds) == 1) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.reference_sample <= SAMPLE_BITS'(ref_val);
      req_chan.measured_sample <= SAMPLE_BITS'(meas_val);
      do @(posedge clock); while (!req_chan.ready);
      expected_drives.push_back(compute_drive(ref_val, meas_val));
   endtask

   function automatic logic [DATA_BITS-1:0] pick_reg_value(int high, int typical);
      int mode;
      mode = $urandom_range(0, 7);
      if (mode == 0)
         return '0;
      if (mode == 1)
         return ALL_ONES;
      if (mode < 4)
         return DATA_BITS'($urandom_range(0, high));
      return DATA_BITS'($urandom_range(0, typical));
   endfunction

   task automatic randomize_registers();
      write_reg(pmc_pkg::REG_STOP_WINDOW, pick_reg_value(SAMPLE_MAX, 16));
      write_reg(pmc_pkg::REG_MIN_DUTY, pick_reg_value(DUTY_MAX, 120));
      write_reg(pmc_pkg::REG_INTEGRAL_LIMIT, pick_reg_value(12000, 3000));
      write_reg(pmc_pkg::REG_KP_NUMERATOR, pick_reg_value(DUTY_MAX, 20));
      write_reg(pmc_pkg::REG_KI_NUMERATOR, pick_reg_value(DUTY_MAX, 20));
      if ($urandom_range(0, 2) == 0)
         write_reg(INDEX_BITS'($urandom_range(int'(pmc_pkg::REG_KI_NUMERATOR) + 1,
                                              (1 << INDEX_BITS) - 1)),
                   DATA_BITS'($urandom()));
   endtask

   // dead band edges, stop, both directions and integrator wind-up at reset settings
   task automatic test_reset_defaults();
      send_sample(512, 512);
      send_sample(514, 512);
      send_sample(515, 512);
      send_sample(509, 512);
      send_sample(SAMPLE_MAX, 0);
      send_sample(SAMPLE_MAX, 0);
      send_sample(SAMPLE_MAX, 0);
      send_sample(0, SAMPLE_MAX);
      send_sample(0, SAMPLE_MAX);
   endtask

   // writes past the last register must leave every setting alone
   task automatic test_ignored_writes();
      wait_for_idle();
      for (int i = int'(pmc_pkg::REG_KI_NUMERATOR) + 1; i < (1 << INDEX_BITS); i++)
         write_reg(INDEX_BITS'(i), ALL_ONES);
      send_sample(515, 512);
      send_sample(400, 700);
   endtask

   // zero gains: outside the dead band the sum is zero, so ccw at min duty
   task automatic test_zero_sum();
      wait_for_idle();
      write_reg(pmc_pkg::REG_KP_NUMERATOR, '0);
      write_reg(pmc_pkg::REG_KI_NUMERATOR, '0);
      write_reg(pmc_pkg::REG_STOP_WINDOW, '0);
      send_sample(100, 99);
      send_sample(99, 100);
      send_sample(0, 0);
   endtask

   // oversized write data keeps only the low bits of each register
   task automatic test_wide_values();
      wait_for_idle();
      write_reg(pmc_pkg::REG_STOP_WINDOW, ALL_ONES);
      send_sample(SAMPLE_MAX, 0);
      send_sample(0, SAMPLE_MAX);
      wait_for_idle();
      write_reg(pmc_pkg::REG_STOP_WINDOW, '0);
      write_reg(pmc_pkg::REG_MIN_DUTY, ALL_ONES);
      write_reg(pmc_pkg::REG_KP_NUMERATOR, ALL_ONES);
      write_reg(pmc_pkg::REG_INTEGRAL_LIMIT, ALL_ONES);
      send_sample(1, 0);
   endtask

   // duty clipped at full scale; a zero limit pins the integrator at zero
   task automatic test_duty_saturation();
      wait_for_idle();
      write_reg(pmc_pkg::REG_MIN_DUTY, '0);
      write_reg(pmc_pkg::REG_INTEGRAL_LIMIT, '0);
      write_reg(pmc_pkg::REG_KP_NUMERATOR, DATA_BITS'(DUTY_MAX));
      write_reg(pmc_pkg::REG_KI_NUMERATOR, DATA_BITS'(DUTY_MAX));
      send_sample(SAMPLE_MAX, 0);
      send_sample(0, SAMPLE_MAX);
      send_sample(5, 4);
      send_sample(4, 5);
   endtask

   // mostly runs of one error sign (integrator wind-up), some near the dead
   // band, some unrelated sample pairs
   task automatic test_random_phase(int n_items, bit quiet);
      int sent, kind, len, sgn, err, mag, abs_err, base, db;
      wait_for_idle();
      randomize_registers();
      if (quiet) begin
         sender_idle_odds = 0;
         receiver_idle_odds = 0;
      end else begin
         sender_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
         receiver_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
      end
      db = int'(reg_model.stop_window);
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 19);
         len = $urandom_range(1, 40);
         sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
         for (int k = 0; k < len && sent < n_items; k++) begin
            if (kind < 14) begin
               if ($urandom_range(0, 3) == 0)
                  mag = db + 1 + int'($urandom_range(0, SAMPLE_MAX));
               else
                  mag = db + 1 + int'($urandom_range(0, 60));
               if (mag > SAMPLE_MAX)
                  mag = SAMPLE_MAX;
               err = sgn * mag;
            end else if (kind < 17) begin
               mag = int'($urandom_range(0, db + 3));
               if (mag > SAMPLE_MAX)
                  mag = SAMPLE_MAX;
               err = ($urandom_range(0, 1) == 1) ? mag : -mag;
            end else begin
               err = int'($urandom_range(0, SAMPLE_MAX)) - int'($urandom_range(0, SAMPLE_MAX));
            end
            abs_err = (err < 0) ? -err : err;
            base = int'($urandom_range(0, SAMPLE_MAX - abs_err));
            if (err >= 0)
               send_sample(base + err, base);
            else
               send_sample(base, base - err);
            sent++;
         end
      end
   endtask

   // result sink: random ready bursts plus in-order compare
   initial begin : rsp_sink
      int        stall_left;
      drive_type got;
      drive_type want;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.duty = rsp_chan.duty;
            got.direction = rsp_chan.direction;
            if (expected_drives.size() == 0) begin
               report_mismatch("unexpected result, duty", int'(got.duty), -1);
            end else begin
               want = expected_drives.pop_front();
               if (got.duty !== want.duty)
                  report_mismatch("duty", int'(got.duty), int'(want.duty));
               if (got.direction !== want.direction)
                  report_mismatch("direction", int'(got.direction), int'(want.direction));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (receiver_idle_odds != 0 && $urandom_range(1, receiver_idle_odds) == 1) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ends a hung run: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.reference_sample <= '0;
      req_chan.measured_sample <= '0;
      reg_model.stop_window = pmc_pkg::RESET_STOP_WINDOW;
      reg_model.min_duty = pmc_pkg::RESET_MIN_DUTY;
      reg_model.integral_limit = pmc_pkg::RESET_INTEGRAL_LIMIT;
      reg_model.kp_numerator = pmc_pkg::RESET_KP_NUMERATOR;
      reg_model.ki_numerator = pmc_pkg::RESET_KI_NUMERATOR;
      integ_model = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      sender_idle_odds = 4;
      receiver_idle_odds = 4;
      test_reset_defaults();
      test_ignored_writes();
      test_zero_sum();
      test_wide_values();
      test_duty_saturation();
      for (int p = 0; p < PHASE_COUNT; p++)
         test_random_phase(PHASE_ITEMS, p == PHASE_COUNT - 1);

      wait_for_idle();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
